// File: hdl/sci_pkg.sv
// Constants shared by the segment / circle intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sci_pkg;
    localparam int OUT_BITS   = 16;                // fraction bits of the segment parameter
    localparam int SRCH_STEPS = OUT_BITS + 1;      // one stage per result bit, 1.0 included
    localparam int VW         = 86;                // vertex term a*k + h*2^16
    localparam int QW         = 104;               // quadratic a*k^2 + 2*h*k*2^16 + c*2^32
    localparam int IN_TW      = 224;               // input tdata width
    localparam int OUT_TW     = 24;                // output tdata width
    localparam int PRE_STAGES = 5;                 // stages before the search init stage
    localparam int NSTG       = PRE_STAGES + SRCH_STEPS + 1;
endpackage
`default_nettype wire

// File: hdl/segment_circle_intersection.sv
// Segment / circle intersection: full pipeline from coordinates to segment parameter.
// Pipeline: 5 setup stages, one decide stage, 17 search stages, one per result bit, each a
//   shift-and-add update of the quadratic.
// Throughput: one item per cycle while m_tready is high; each stage holds a valid bit, so
//   bubbles close up; an item enters while a result waits at the output if a stage is empty.
// Reset: aresetn, synchronous, active low, clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_intersection
    import sci_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96],
    // center_x[159:128], center_y[191:160], circle_radius[222:192], zero[223]
    input  wire [IN_TW-1:0]    s_tdata,
    output logic               m_tvalid,
    input  wire                m_tready,
    // hit[0], seg_param[17:1], near_root[18], zero[23:19]
    output logic [OUT_TW-1:0]  m_tdata
);
    localparam int LAST = NSTG - 1;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // stage may load when empty or when its content moves on
    always_comb begin
        en[LAST] = !vld_reg[LAST] || m_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: differences
    logic signed [32:0] dx_reg, dy_reg, fx_reg, fy_reg;
    logic        [30:0] r_reg;
    logic signed [32:0] sx, sy, ex, ey, cx, cy;

    assign sx = {s_tdata[31],  s_tdata[31:0]};
    assign sy = {s_tdata[63],  s_tdata[63:32]};
    assign ex = {s_tdata[95],  s_tdata[95:64]};
    assign ey = {s_tdata[127], s_tdata[127:96]};
    assign cx = {s_tdata[159], s_tdata[159:128]};
    assign cy = {s_tdata[191], s_tdata[191:160]};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx_reg <= ex - sx;
            dy_reg <= ey - sy;
            fx_reg <= sx - cx;
            fy_reg <= sy - cy;
            r_reg  <= s_tdata[222:192];
        end
    end

    // stage 2: products
    logic signed [65:0] pdd_x_reg, pdd_y_reg, pfd_x_reg, pfd_y_reg;
    logic signed [65:0] pff_x_reg, pff_y_reg, pxy_reg, pyx_reg;
    logic        [61:0] rsq2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pdd_x_reg <= dx_reg * dx_reg;
            pdd_y_reg <= dy_reg * dy_reg;
            pfd_x_reg <= fx_reg * dx_reg;
            pfd_y_reg <= fy_reg * dy_reg;
            pff_x_reg <= fx_reg * fx_reg;
            pff_y_reg <= fy_reg * fy_reg;
            pxy_reg   <= fx_reg * dy_reg;
            pyx_reg   <= fy_reg * dx_reg;
            rsq2_reg  <= r_reg * r_reg;
        end
    end

    // stage 3: quadratic coefficients and cross product
    logic signed [66:0] a_sum, ff_sum;
    logic        [64:0] a3_reg;
    logic signed [66:0] h3_reg, c3_reg, cross3_reg;
    logic        [61:0] rsq3_reg;

    assign a_sum  = pdd_x_reg + pdd_y_reg;
    assign ff_sum = pff_x_reg + pff_y_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            a3_reg     <= a_sum[64:0];
            h3_reg     <= pfd_x_reg + pfd_y_reg;
            c3_reg     <= ff_sum - $signed({5'b0, rsq2_reg});
            cross3_reg <= pxy_reg - pyx_reg;
            rsq3_reg   <= rsq2_reg;
        end
    end

    // stage 4: partial products of the discriminant, boundary sums
    // h*h - a*c equals r^2*a - cross^2, so compare those two
    logic signed [66:0] cross_abs;
    logic        [64:0] cm;
    logic        [63:0] pp_hh_reg;
    logic        [64:0] pp_hl_reg;
    logic        [65:0] pp_ll_reg;
    logic        [63:0] pr_hh_reg, pr_lh_reg;
    logic        [62:0] pr_hl_reg, pr_ll_reg;
    logic        [64:0] a4_reg;
    logic signed [66:0] h4_reg, c4_reg;
    logic signed [67:0] ah4_reg;
    logic signed [68:0] p14_reg;
    logic               az4_reg;

    assign cross_abs = cross3_reg[66] ? -cross3_reg : cross3_reg;
    assign cm        = cross_abs[64:0];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pp_hh_reg <= cm[64:33] * cm[64:33];
            pp_hl_reg <= cm[64:33] * cm[32:0];
            pp_ll_reg <= cm[32:0] * cm[32:0];
            pr_hh_reg <= rsq3_reg[61:31] * a3_reg[64:32];
            pr_hl_reg <= rsq3_reg[61:31] * a3_reg[31:0];
            pr_lh_reg <= rsq3_reg[30:0] * a3_reg[64:32];
            pr_ll_reg <= rsq3_reg[30:0] * a3_reg[31:0];
            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            c4_reg    <= c3_reg;
            ah4_reg   <= $signed({3'b0, a3_reg}) + h3_reg;
            p14_reg   <= $signed({4'b0, a3_reg}) + (h3_reg <<< 1) + c3_reg;
            az4_reg   <= (a3_reg == '0);
        end
    end

    // stage 5: sum partial products, classify roots against [0,1]
    logic [130:0] cr2_reg, ra_reg;
    logic [64:0]  a5_reg;
    logic signed [66:0] h5_reg, c5_reg;
    logic az5_reg, far_ok5_reg, near_ok5_reg;
    logic h_le0, c_le0, c_ge0, ah_ge0, p1_ge0, p1_le0;

    assign h_le0  = h4_reg[66] || (h4_reg == '0);
    assign c_le0  = c4_reg[66] || (c4_reg == '0);
    assign c_ge0  = !c4_reg[66];
    assign ah_ge0 = !ah4_reg[67];
    assign p1_ge0 = !p14_reg[68];
    assign p1_le0 = p14_reg[68] || (p14_reg == '0);

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            cr2_reg <= ({67'b0, pp_hh_reg} << 66) + ({66'b0, pp_hl_reg} << 34)
                       + {65'b0, pp_ll_reg};
            ra_reg  <= ({67'b0, pr_hh_reg} << 63) + ({68'b0, pr_hl_reg} << 31)
                       + ({67'b0, pr_lh_reg} << 32) + {68'b0, pr_ll_reg};
            a5_reg       <= a4_reg;
            h5_reg       <= h4_reg;
            c5_reg       <= c4_reg;
            az5_reg      <= az4_reg;
            far_ok5_reg  <= (h_le0 || c_le0) && ah_ge0 && p1_ge0;
            near_ok5_reg <= h_le0 && c_ge0 && (ah_ge0 || p1_le0);
        end
    end

    // search pipeline: index 0 is the decide stage, 1..SRCH_STEPS one result bit each
    logic [OUT_BITS:0]   lo_reg   [0:SRCH_STEPS];
    logic signed [VW-1:0] v_reg   [0:SRCH_STEPS];
    logic signed [QW-1:0] q_reg   [0:SRCH_STEPS];
    logic [64:0]         as_reg   [0:SRCH_STEPS];
    logic                far_reg  [0:SRCH_STEPS];
    logic                ok_reg   [0:SRCH_STEPS];
    logic                done_reg [0:SRCH_STEPS];

    always_ff @(posedge aclk) begin
        if (en[PRE_STAGES]) begin
            lo_reg[0]   <= '0;
            v_reg[0]    <= VW'(h5_reg) <<< OUT_BITS;
            q_reg[0]    <= QW'(c5_reg) <<< (2 * OUT_BITS);
            as_reg[0]   <= a5_reg;
            far_reg[0]  <= far_ok5_reg;
            ok_reg[0]   <= !az5_reg && (cr2_reg <= ra_reg) && (far_ok5_reg || near_ok5_reg);
            done_reg[0] <= 1'b0;
        end
    end

    for (genvar k = 1; k <= SRCH_STEPS; k++) begin : g_srch
        localparam int J = SRCH_STEPS - k;
        logic signed [VW-1:0] vc;
        logic signed [QW-1:0] qc;
        logic vc_le0, qc_le0, qc_ge0, pred, take;

        // candidate k = lo + 2^J: vert grows by a*2^J, quadratic by 2^(J+1)*vert + a*2^(2J)
        always_comb begin
            vc     = v_reg[k-1] + ($signed({{(VW-65){1'b0}}, as_reg[k-1]}) <<< J);
            qc     = q_reg[k-1] + (QW'(v_reg[k-1]) <<< (J + 1))
                     + ($signed({{(QW-65){1'b0}}, as_reg[k-1]}) <<< (2 * J));
            vc_le0 = vc[VW-1] || (vc == '0);
            qc_le0 = qc[QW-1] || (qc == '0);
            qc_ge0 = !qc[QW-1];
            pred   = far_reg[k-1] ? (vc_le0 || qc_le0) : (vc_le0 && qc_ge0);
            take   = ok_reg[k-1] && !done_reg[k-1] && pred;
        end

        always_ff @(posedge aclk) begin
            if (en[PRE_STAGES + k]) begin
                as_reg[k]  <= as_reg[k-1];
                far_reg[k] <= far_reg[k-1];
                ok_reg[k]  <= ok_reg[k-1];
                if (take) begin
                    lo_reg[k] <= lo_reg[k-1] | ((OUT_BITS + 1)'(1) << J);
                    v_reg[k]  <= vc;
                    q_reg[k]  <= qc;
                end else begin
                    lo_reg[k] <= lo_reg[k-1];
                    v_reg[k]  <= v_reg[k-1];
                    q_reg[k]  <= q_reg[k-1];
                end
                // a whole 1.0 leaves no room for lower bits
                done_reg[k] <= done_reg[k-1] || ((J == OUT_BITS) && take);
            end
        end
    end

    logic              hit_o, near_o;
    logic [OUT_BITS:0] param_o;

    assign hit_o    = ok_reg[SRCH_STEPS];
    assign param_o  = hit_o ? lo_reg[SRCH_STEPS] : '0;
    assign near_o   = hit_o && !far_reg[SRCH_STEPS];
    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {{(OUT_TW - OUT_BITS - 3){1'b0}}, near_o, param_o, hit_o};

    a_param_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (param_o <= (OUT_BITS + 1)'(1) << OUT_BITS))
        else $error("segment parameter above 1.0");
    a_miss_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !hit_o) |-> (param_o == '0 && !near_o))
        else $error("miss carries nonzero fields");
    a_done_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && done_reg[SRCH_STEPS]) |-> (param_o == (OUT_BITS + 1)'(1) << OUT_BITS))
        else $error("early stop without full parameter");
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item not loaded");
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[PRE_STAGES] && !en[PRE_STAGES]) |=> vld_reg[PRE_STAGES])
        else $error("stalled item dropped");
endmodule
`default_nettype wire
